// ----- sv/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Windowed peak level meter: shared definitions
// Widths, register indexes and fixed-point constants for the meter and its
// checker.
// ----------------------------------------------------------------------------
package wpm_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int LEVEL_BITS     = 25;
	localparam int WIN_BITS       = 17;
	localparam int CFG_IDX_BITS   = 4;
	localparam int CFG_DATA_BITS  = WIN_BITS;

	// log2 datapath
	localparam int FRAC_BITS      = 16;
	localparam int MANT_BITS      = 31;
	localparam int EXP_BITS       = $clog2(SAMPLE_BITS);
	localparam int NEG_BITS       = EXP_BITS + FRAC_BITS;
	localparam int SCALE_BITS     = 19;
	localparam int PROD_BITS      = NEG_BITS + SCALE_BITS;
	localparam int ROUND_SHIFT    = 24;
	localparam int Q_BITS         = PROD_BITS - ROUND_SHIFT;

	// round(20*log10(2) * 2^16)
	localparam logic [SCALE_BITS-1:0] DB_PER_LOG2_Q16 = SCALE_BITS'(394566);
	localparam logic signed [LEVEL_BITS-1:0] DB_FLOOR_Q8 = LEVEL_BITS'(-255744);
	localparam logic [WIN_BITS-1:0] WIN_LEN_RESET = WIN_BITS'(512);

	// result buffer, also the bound on words in flight
	localparam int FIFO_DEPTH     = 32;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
	localparam int USED_BITS      = FIFO_AW + 1;

	// accept-to-output latency in cycles
	localparam int PIPE_LAT       = FRAC_BITS + 5;

	typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
	typedef logic        [SAMPLE_BITS-1:0]  mag_t;
	typedef logic signed [LEVEL_BITS-1:0]   level_t;
	typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic        [CFG_DATA_BITS-1:0] cfg_data_t;
	typedef logic        [MANT_BITS-1:0]    mant_t;
	typedef logic        [FRAC_BITS-1:0]    frac_t;
	typedef logic        [EXP_BITS-1:0]     exp_t;

	localparam cfg_idx_t REG_WINDOW_LEN = CFG_IDX_BITS'(0);
	localparam cfg_idx_t REG_DB_MODE    = CFG_IDX_BITS'(1);

endpackage

// ----- sv/windowed_peak_level_meter_unit.sv -----
// ----------------------------------------------------------------------------
// Windowed peak level meter
// Tracks the peak sample magnitude over a window and reports it, linear or
// as Q8.8 dBFS, each time a window closes.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid/sample_ready/sample): one signed word per
//   accepted audio sample. level channel (level_valid/level_ready/level):
//   one word each time a window closes; the first sample always closes one,
//   then every window_len samples. cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data): index 0 writes window_len, index 1 writes db_mode;
//   other indexes are ignored. cfg_ready is always high.
//   Path: a level word passes the input, peak, squaring, scaling and output
//   registers, waiting in the buffer while the output stalls; linear and dB
//   words take the same path, so the order is kept.
//   Throughput: one sample per cycle unless stalled. The dB path is a 16-stage
//   squaring pipeline (one multiplier per stage), then a scaling multiply.
//   Stalls: finished words wait in a 32-word buffer. Every accepted sample
//   holds a slot until it is found to close no window or its word is taken,
//   so sample_ready drops only once 32 slots are held.
//   Reset: peak and countdown clear, window_len returns to 512, db_mode to
//   linear, and the pipeline and buffer empty.
// ----------------------------------------------------------------------------
module windowed_peak_level_meter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  wpm_pkg::sample_t   sample,
	output logic               level_valid,
	input  logic               level_ready,
	output wpm_pkg::level_t    level,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  wpm_pkg::cfg_idx_t  cfg_index,
	input  wpm_pkg::cfg_data_t cfg_data
);
	import wpm_pkg::*;

	logic                in_acc;
	logic                out_pop;
	logic                drop;

	logic [WIN_BITS-1:0] window_len_q;
	logic                db_mode_q;

	logic                v_s0;
	sample_t             sample_s0;

	mag_t                mag_c;
	mag_t                peak_new_c;
	logic                closes_c;
	mag_t                peak_hold_q;
	logic [WIN_BITS-1:0] countdown_q;

	logic                v_s1;
	mag_t                peak_s1;
	logic                db_s1;

	exp_t                exp_c;
	exp_t                lz_c;
	mag_t                shifted_c;
	logic [SAMPLE_BITS+MANT_BITS-1:0] mext_c;

	// index 0 is stage 2, index k is stage k+2
	logic                sq_v_s    [FRAC_BITS+1];
	mant_t               sq_mant_s [FRAC_BITS+1];
	frac_t               sq_frac_s [FRAC_BITS+1];
	exp_t                sq_exp_s  [FRAC_BITS+1];
	mag_t                sq_peak_s [FRAC_BITS+1];
	logic                sq_db_s   [FRAC_BITS+1];
	logic [MANT_BITS:0]  sq_c      [FRAC_BITS];

	exp_t                ediff_c;
	logic [NEG_BITS-1:0] neg_c;
	logic                v_s19;
	logic [PROD_BITS-1:0] prod_s19;
	mag_t                peak_s19;
	logic                db_s19;

	logic [PROD_BITS-1:0] rounded_c;
	logic [Q_BITS-1:0]   q_c;
	level_t              db_level_c;
	level_t              level_c;

	level_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [USED_BITS-1:0] cnt_q;
	logic [USED_BITS-1:0] used_q;
	level_t              level_q;
	logic                out_v_q;
	logic                out_load;
	logic                mem_rd;
	logic                mem_wr;

	assign in_acc  = sample_valid && sample_ready;
	assign out_pop = level_valid && level_ready;
	assign cfg_ready = 1'b1;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WIN_LEN_RESET;
			db_mode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_data[WIN_BITS-1:0];
				REG_DB_MODE:    db_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s0 <= sample;
		end
	end

	// Peak tracking and window countdown
	always_comb begin
		mag_c      = sample_s0[SAMPLE_BITS-1] ? mag_t'(~sample_s0 + 1'b1) : mag_t'(sample_s0);
		peak_new_c = (mag_c > peak_hold_q) ? mag_c : peak_hold_q;
		closes_c   = (countdown_q == '0);
	end

	assign drop = v_s0 && !closes_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_hold_q <= '0;
			countdown_q <= '0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= v_s0 && closes_c;
			if (v_s0) begin
				if (closes_c) begin
					peak_hold_q <= '0;
					countdown_q <= (window_len_q == '0) ? '0 : window_len_q - 1'b1;
				end else begin
					peak_hold_q <= peak_new_c;
					countdown_q <= countdown_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		peak_s1 <= peak_new_c;
		db_s1   <= db_mode_q;
	end

	// Normalise the peak to Q1.30
	always_comb begin
		exp_c = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (peak_s1[i]) begin
				exp_c = EXP_BITS'(i);
			end
		end
		lz_c      = EXP_BITS'(SAMPLE_BITS - 1) - exp_c;
		shifted_c = peak_s1 << lz_c;
		mext_c    = {shifted_c, MANT_BITS'(0)};
	end

	// Squaring stages: one fraction bit of log2 per stage
	always_comb begin
		logic [2*MANT_BITS-1:0] prod;
		for (int k = 0; k < FRAC_BITS; k++) begin
			prod     = {{MANT_BITS{1'b0}}, sq_mant_s[k]} * {{MANT_BITS{1'b0}}, sq_mant_s[k]};
			sq_c[k]  = prod[2*MANT_BITS-1:MANT_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= FRAC_BITS; k++) begin
				sq_v_s[k] <= 1'b0;
			end
		end else begin
			sq_v_s[0] <= v_s1;
			for (int k = 0; k < FRAC_BITS; k++) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_mant_s[0] <= mext_c[SAMPLE_BITS+MANT_BITS-1 -: MANT_BITS];
		sq_frac_s[0] <= '0;
		sq_exp_s[0]  <= exp_c;
		sq_peak_s[0] <= peak_s1;
		sq_db_s[0]   <= db_s1;
		for (int k = 0; k < FRAC_BITS; k++) begin
			// square >= 2.0: set the bit and halve
			if (sq_c[k][MANT_BITS]) begin
				sq_mant_s[k+1] <= sq_c[k][MANT_BITS:1];
				sq_frac_s[k+1] <= sq_frac_s[k] | (frac_t'(1) << (FRAC_BITS - 1 - k));
			end else begin
				sq_mant_s[k+1] <= sq_c[k][MANT_BITS-1:0];
				sq_frac_s[k+1] <= sq_frac_s[k];
			end
			sq_exp_s[k+1]  <= sq_exp_s[k];
			sq_peak_s[k+1] <= sq_peak_s[k];
			sq_db_s[k+1]   <= sq_db_s[k];
		end
	end

	// Scale -log2 to dB
	always_comb begin
		ediff_c = EXP_BITS'(SAMPLE_BITS - 1) - sq_exp_s[FRAC_BITS];
		neg_c   = {ediff_c, FRAC_BITS'(0)} - NEG_BITS'(sq_frac_s[FRAC_BITS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s19 <= 1'b0;
		end else begin
			v_s19 <= sq_v_s[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		prod_s19 <= PROD_BITS'(neg_c) * PROD_BITS'(DB_PER_LOG2_Q16);
		peak_s19 <= sq_peak_s[FRAC_BITS];
		db_s19   <= sq_db_s[FRAC_BITS];
	end

	// Round to nearest and pick the report
	always_comb begin
		rounded_c  = prod_s19 + (PROD_BITS'(1) << (ROUND_SHIFT - 1));
		q_c        = rounded_c[PROD_BITS-1:ROUND_SHIFT];
		db_level_c = -level_t'(LEVEL_BITS'(q_c));
		if (!db_s19) begin
			level_c = level_t'(LEVEL_BITS'(peak_s19));
		end else if (peak_s19 == '0) begin
			level_c = DB_FLOOR_Q8;
		end else begin
			level_c = db_level_c;
		end
	end

	// Result buffer: a word goes straight to the output register when that is
	// free and nothing is queued, else it queues behind the stored words
	assign out_load = !out_v_q || out_pop;
	assign mem_rd   = out_load && (cnt_q != '0);
	assign mem_wr   = v_s19 && !(out_load && (cnt_q == '0));

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[wr_ptr_q] <= level_c;
		end
		if (mem_rd) begin
			level_q <= mem_q[rd_ptr_q];
		end else if (out_load && v_s19) begin
			level_q <= level_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			used_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (mem_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (mem_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (out_load) begin
				out_v_q <= mem_rd || v_s19;
			end
			cnt_q  <= cnt_q + USED_BITS'(mem_wr) - USED_BITS'(mem_rd);
			// hold a slot per sample until it drops out or its word leaves
			used_q <= used_q + USED_BITS'(in_acc) - USED_BITS'(drop) - USED_BITS'(out_pop);
		end
	end

	assign sample_ready = (used_q < USED_BITS'(FIFO_DEPTH));
	assign level_valid  = out_v_q;
	assign level        = level_q;

endmodule

// ----- sv/wpm_checker.sv -----
// ----------------------------------------------------------------------------
// Windowed peak level meter: port checker
// Watches the meter's ports for handshake, flow and latency slips.
// ----------------------------------------------------------------------------
module wpm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input wpm_pkg::sample_t   sample,
	input logic               level_valid,
	input logic               level_ready,
	input wpm_pkg::level_t    level,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input wpm_pkg::cfg_idx_t  cfg_index,
	input wpm_pkg::cfg_data_t cfg_data
);
	import wpm_pkg::*;

	// a stalled level word holds
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid && !level_ready |=> level_valid && $stable(level))
		else $error("level word changed or vanished while stalled");

	// the sample side closes only after taking a word
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |-> $past(sample_valid && sample_ready))
		else $error("sample_ready dropped without an accepted word");

	// a fresh level word comes from a sample taken a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(level_valid) |-> $past(sample_valid && sample_ready, PIPE_LAT))
		else $error("level word appeared without a matching sample");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind windowed_peak_level_meter_unit wpm_checker u_wpm_checker (.*);

// ----- tb/windowed_peak_level_meter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Windowed peak level meter: self-checking bench
// Drives samples and register writes through valid/ready channels with random
// gaps and stalls, predicts every level word from its own peak/countdown
// tracker and checks the words in order as they leave the meter.
// ----------------------------------------------------------------------------
module windowed_peak_level_meter_unit_tb;
	import wpm_pkg::*;

	localparam cfg_idx_t REG_SPARE_LO  = CFG_IDX_BITS'(2);
	localparam cfg_idx_t REG_SPARE_HI  = CFG_IDX_BITS'(15);
	localparam int       RANDOM_ITEMS  = 750;
	localparam int       LONG_HOLD     = 400;
	localparam longint   TIMEOUT       = 64'd18_000_000;

	class level_scoreboard;
		mag_t                peak_hold;
		logic [WIN_BITS-1:0] countdown;
		logic [WIN_BITS-1:0] window_len;
		logic                db_mode;
		level_t              pending_levels[$];
		int unsigned         faults;

		function new();
			peak_hold  = '0;
			countdown  = '0;
			window_len = WIN_LEN_RESET;
			db_mode    = 1'b0;
			faults     = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
			REG_WINDOW_LEN: window_len = data;
			REG_DB_MODE:    db_mode = data[0];
			default: ;
			endcase
		endfunction

		// log2 by repeated squaring, then scale to Q8.8 dB
		function level_t db_level(mag_t pk);
			int                e;
			int                b;
			longint unsigned   m;
			longint            lq;
			longint unsigned   neg;
			longint unsigned   q;
			if (pk == '0)
				return DB_FLOOR_Q8;
			e = 0;
			for (b = 0; b < SAMPLE_BITS; b++)
				if (pk[b])
					e = b;
			m  = 64'(pk) << (30 - e);
			lq = (e - (SAMPLE_BITS - 1)) * (1 << FRAC_BITS);
			for (b = FRAC_BITS - 1; b >= 0; b--) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					lq += longint'(1) << b;
					m >>= 1;
				end
			end
			if (lq >= 0)
				return '0;
			neg = -lq;
			q   = (neg * 64'(DB_PER_LOG2_Q16) + (64'd1 << 23)) >> 24;
			return level_t'(-longint'(q));
		endfunction

		function void take_sample(sample_t s);
			mag_t mag;
			mag = s[SAMPLE_BITS-1] ? mag_t'(~s) + 1'b1 : mag_t'(s);
			if (mag > peak_hold)
				peak_hold = mag;
			if (countdown != '0) begin
				countdown = countdown - 1'b1;
				return;
			end
			pending_levels.push_back(db_mode ? db_level(peak_hold) : level_t'({1'b0, peak_hold}));
			peak_hold = '0;
			countdown = (window_len == '0) ? '0 : window_len - 1'b1;
		endfunction

		function void match_level(level_t got);
			level_t want;
			if (pending_levels.size() == 0) begin
				$display("%0t: level word with none expected, expected none, got %0d", $time, got);
				faults++;
				return;
			end
			want = pending_levels.pop_front();
			if (got !== want) begin
				$display("%0t: level mismatch, expected %0d, got %0d", $time, want, got);
				faults++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      sample_valid;
	logic      sample_ready;
	sample_t   sample_word;
	logic      level_valid;
	logic      level_ready;
	level_t    level_word;
	logic      cfg_valid;
	logic      cfg_ready;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;

	bit tx_gaps;
	bit rx_gaps;
	bit want_long_hold;

	level_scoreboard board;

	windowed_peak_level_meter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample_word),
		.level_valid  (level_valid),
		.level_ready  (level_ready),
		.level        (level_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && level_valid && level_ready)
			board.match_level(level_word);
	end

	// level receiver: random stalls plus one long hold on request
	initial begin
		int hold_left;
		bit hold_begun;
		bit stall;
		hold_left   = 0;
		hold_begun  = 1'b0;
		level_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (want_long_hold && !hold_begun) begin
				hold_left  = LONG_HOLD;
				hold_begun = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall = 1'b1;
			end else begin
				stall = rx_gaps && ($urandom_range(0, 99) < 27);
			end
			@(negedge clk);
			level_ready = !stall;
		end
	end

	function automatic sample_t pick_sample();
		sample_t p;
		case ($urandom_range(0, 9))
		0: return $urandom_range(0, 1) ? sample_t'(-8388608) : sample_t'(8388607);
		1: return '0;
		2, 3: return sample_t'($urandom_range(0, 511)) - sample_t'(256);
		4: begin
			p = sample_t'(1) << $urandom_range(0, 22);
			return $urandom_range(0, 1) ? -p : p;
		end
		default: return sample_t'($urandom());
		endcase
	endfunction

	// entered and left at a falling edge; valid stays high on return
	task automatic push_sample(input sample_t v);
		while (tx_gaps && $urandom_range(0, 99) < 27) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample_word  = v;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
		board.take_sample(v);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		board.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_valid = 1'b0;
		do @(negedge clk); while (board.pending_levels.size() != 0);
	endtask

	// let samples that close no window clear the pipeline too
	task automatic settle();
		wait_drained();
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic finish_window();
		while (board.countdown != '0)
			push_sample(pick_sample());
		push_sample(pick_sample());
	endtask

	task automatic push_corners();
		push_sample(sample_t'(0));
		push_sample(sample_t'(1));
		push_sample(sample_t'(-1));
		push_sample(sample_t'(8388607));
		push_sample(sample_t'(-8388608));
		push_sample(sample_t'(4194304));
		push_sample(sample_t'(-4194305));
		push_sample(sample_t'(181));
	endtask

	task automatic pick_setting();
		cfg_data_t win;
		bit        db_first;
		case ($urandom_range(0, 9))
		0: win = '0;
		1, 2: win = cfg_data_t'(1);
		3, 4, 5, 6: win = cfg_data_t'($urandom_range(2, 8));
		7, 8: win = cfg_data_t'($urandom_range(9, 40));
		default: win = cfg_data_t'($urandom_range(41, 300));
		endcase
		db_first = $urandom_range(0, 1);
		if (db_first)
			cfg_write(REG_DB_MODE, cfg_data_t'($urandom()));
		cfg_write(REG_WINDOW_LEN, win);
		if (!db_first)
			cfg_write(REG_DB_MODE, cfg_data_t'($urandom()));
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, cfg_data_t'($urandom()));
	endtask

	// write a large length mid-window, then drop back before the window
	// closes: the running countdown holds and only the later length applies
	task automatic big_window(input cfg_data_t len);
		cfg_write(REG_WINDOW_LEN, cfg_data_t'(6));
		cfg_write(REG_DB_MODE, cfg_data_t'($urandom()));
		finish_window();
		push_sample(pick_sample());
		push_sample(pick_sample());
		settle();
		cfg_write(REG_WINDOW_LEN, len);
		push_sample(pick_sample());
		settle();
		cfg_write(REG_WINDOW_LEN, cfg_data_t'($urandom_range(1, 4)));
		finish_window();
	endtask

	initial begin
		int random_done;
		int phase;
		int n;
		int drain_wait;
		board          = new();
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		sample_word    = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		tx_gaps        = 1'b1;
		rx_gaps        = 1'b1;
		want_long_hold = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: linear, window of 512, first sample closes a window
		push_sample(sample_t'(-8388608));
		settle();
		cfg_write(REG_WINDOW_LEN, cfg_data_t'(1));
		finish_window();

		push_corners();
		settle();
		cfg_write(REG_DB_MODE, cfg_data_t'(1));
		push_corners();

		// zero length behaves as one sample
		settle();
		cfg_write(REG_WINDOW_LEN, '0);
		cfg_write(REG_SPARE_LO, cfg_data_t'($urandom()));
		push_sample(sample_t'(0));
		push_sample(sample_t'(8388607));

		// peak includes the closing sample
		settle();
		cfg_write(REG_WINDOW_LEN, cfg_data_t'(3));
		cfg_write(REG_SPARE_HI, '1);
		push_sample(sample_t'(5));
		push_sample(sample_t'(-300));
		push_sample(sample_t'(7));
		push_sample(sample_t'(0));
		push_sample(sample_t'(0));
		push_sample(sample_t'(0));

		random_done = 0;
		for (phase = 0; random_done < RANDOM_ITEMS; phase++) begin
			settle();
			tx_gaps = !(phase == 2 || phase == 4 || phase == 6);
			rx_gaps = tx_gaps;
			if (phase == 2 || phase == 4) begin
				big_window(phase == 2 ? cfg_data_t'(65536) : '1);
			end else if (phase == 3) begin
				// hold the receiver off so the result buffer fills and stalls samples
				cfg_write(REG_WINDOW_LEN, cfg_data_t'(1));
				cfg_write(REG_DB_MODE, cfg_data_t'($urandom()));
				want_long_hold = 1'b1;
				repeat (120)
					push_sample(pick_sample());
				random_done += 120;
			end else begin
				pick_setting();
				n = $urandom_range(30, 110);
				repeat (n) begin
					if ($urandom_range(0, 49) == 0)
						wait_drained();
					push_sample(pick_sample());
				end
				random_done += n;
			end
		end

		sample_valid = 1'b0;
		drain_wait   = 0;
		while (board.pending_levels.size() != 0 && drain_wait < 20000) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (PIPE_LAT + 10) @(negedge clk);
		if (board.pending_levels.size() != 0) begin
			$display("%0t: level word missing, expected %0d, got nothing (%0d outstanding)",
				$time, board.pending_levels[0], board.pending_levels.size());
			board.faults++;
		end
		if (board.faults == 0)
			$display("windowed_peak_level_meter_unit_tb: done, clean");
		else
			$display("windowed_peak_level_meter_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("windowed_peak_level_meter_unit_tb: done, errors");
		$finish;
	end

endmodule

// ----- windowed_peak_level_meter_unit.f -----
sv/wpm_pkg.sv
sv/windowed_peak_level_meter_unit.sv
sv/wpm_checker.sv
tb/windowed_peak_level_meter_unit_tb.sv
